FILE: design/bstrm_pkg.sv
// Package with shared types and constants for the range-minimum unit.
package bstrm_pkg;

    localparam int MaxElems    = 1024;
    localparam int BlockSize   = 16;
    localparam int TableLevels = 6;
    localparam int NumBlocks   = MaxElems / BlockSize + 1;
    localparam int IdxW        = $clog2(MaxElems);
    localparam int CntW        = IdxW + 1;
    localparam int BlkW        = $clog2(NumBlocks);
    localparam int OffW        = $clog2(BlockSize);
    localparam int LevW        = (TableLevels > 1) ? $clog2(TableLevels) : 1;
    localparam int TabAw       = $clog2(TableLevels * NumBlocks);
    localparam int PairW       = 48;

    localparam logic [1:0] OpLoad  = 2'd0;
    localparam logic [1:0] OpBuild = 2'd1;
    localparam logic [1:0] OpQuery = 2'd2;
    localparam logic [1:0] OpNop   = 2'd3;

    localparam logic [PairW-1:0] NeutralPair = {32'hFFFF_FFFF, 16'h0000};

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] elem_key;
        logic [15:0]        elem_payload;
        logic [9:0]         range_low;
        logic [9:0]         range_high;
    } t_in;

    typedef struct packed {
        logic signed [31:0] min_key;
        logic [15:0]        min_payload;
        logic               empty_range;
        logic               error;
    } t_out;

    // Minimum of two pairs in unsigned (sign-flipped) order.
    function automatic logic [PairW-1:0] pmin(input logic [PairW-1:0] a,
                                              input logic [PairW-1:0] b);
        pmin = (a < b) ? a : b;
    endfunction

endpackage

FILE: design/block_sparse_table_range_min_unit.sv
// Top level of the block sparse-table range-minimum unit.
//
//  channel | signals                 | direction
//  input   | i_valid, o_stall, i_in  | into block
//  output  | o_valid, i_stall, o_out | out of block
//
// A load is written while idle and the block stays ready for the next transaction;
// a load into a full table offers an error result instead. A query result is
// offered right after the accepting edge for an error or an empty range, after
// S_QSCAN and S_QFIN for a same-block scan (one read a cycle through the shared
// compare unit), and after S_QSUF, S_QPRE, S_QT1, S_QT2 and S_QFIN otherwise.
// Build runs a prefix pass over all elements, a suffix pass over the whole-block
// elements, level 0 per block and two reads and one write per entry on higher levels.
// Reset is synchronous and clears only state, count, built, overflow and read-valid flags.
// While a result waits under output stall, no new transaction is accepted.
module block_sparse_table_range_min_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  bstrm_pkg::t_in   i_in,
    output logic             o_valid,
    input  logic             i_stall,
    output bstrm_pkg::t_out  o_out
);
    localparam int IdxW  = bstrm_pkg::IdxW;
    localparam int CntW  = bstrm_pkg::CntW;
    localparam int BlkW  = bstrm_pkg::BlkW;
    localparam int OffW  = bstrm_pkg::OffW;
    localparam int LevW  = bstrm_pkg::LevW;
    localparam int TabAw = bstrm_pkg::TabAw;
    localparam int PairW = bstrm_pkg::PairW;
    localparam int Bs    = bstrm_pkg::BlockSize;
    localparam int Nb    = bstrm_pkg::NumBlocks;

    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_SUF, S_TAB0, S_TABL, S_QSCAN, S_QSUF, S_QPRE,
        S_QT1, S_QT2, S_QFIN, S_OUT
    } t_state;

    t_state r_state;
    logic [CntW-1:0] r_count;
    logic r_built, r_ovf;
    logic [IdxW-1:0] r_lo, r_hi, r_i;
    logic [BlkW-1:0] r_lb, r_rb, r_bi;
    logic [LevW-1:0] r_lev;
    logic [PairW-1:0] r_acc, r_prev;
    logic r_have, r_first, r_rdv, r_tabq;
    logic [IdxW-1:0] r_rdidx;
    bstrm_pkg::t_out r_out;

    // Memory ports.
    logic v_we, p_we, s_we, t_we;
    logic [IdxW-1:0] v_wa, p_wa, s_wa, v_ra, p_ra, s_ra;
    logic [TabAw-1:0] t_wa, t_ra;
    logic [PairW-1:0] v_wd, p_wd, s_wd, t_wd, v_rd, p_rd, s_rd, t_rd;

    bstrm_ram #(.Depth(bstrm_pkg::MaxElems), .Width(PairW)) u_val (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));
    bstrm_ram #(.Depth(bstrm_pkg::MaxElems), .Width(PairW)) u_pre (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));
    bstrm_ram #(.Depth(bstrm_pkg::MaxElems), .Width(PairW)) u_suf (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    bstrm_ram #(.Depth(bstrm_pkg::TableLevels * Nb), .Width(PairW)) u_tab (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd));

    function automatic logic [TabAw-1:0] taddr(input logic [LevW-1:0] l,
                                               input logic [BlkW-1:0] b);
        taddr = TabAw'(l * Nb) + TabAw'(b);
    endfunction

    // Turns a stored pair back into a result with a signed key.
    function automatic bstrm_pkg::t_out to_out(input logic [PairW-1:0] p,
                                               input logic empty_flag,
                                               input logic err_flag);
        bstrm_pkg::t_out res;
        res.min_key     = p[PairW-1:16] ^ 32'h8000_0000;
        res.min_payload = p[15:0];
        res.empty_range = empty_flag;
        res.error       = err_flag;
        return res;
    endfunction

    logic [BlkW-1:0] w_nb;
    assign w_nb = BlkW'(r_count >> OffW);

    // Shared compare unit: one pair minimum per cycle.
    logic [PairW-1:0] w_ca, w_cb, w_min;
    assign w_min = bstrm_pkg::pmin(w_ca, w_cb);

    logic [PairW-1:0] w_rd;
    always_comb begin
        case (r_state)
            S_PRE, S_QSCAN:  w_rd = v_rd;
            S_SUF:           w_rd = v_rd;
            S_TAB0:          w_rd = s_rd;
            S_QT1:           w_rd = r_prev;
            default:         w_rd = t_rd;
        endcase
    end
    assign w_ca = r_acc;
    assign w_cb = w_rd;

    // Level for the whole-block span.
    logic [BlkW:0] w_cnt;
    logic [LevW-1:0] w_lev;
    always_comb begin
        w_cnt = {1'b0, r_rb} - {1'b0, r_lb} + 1'b1;
        w_lev = '0;
        for (int l = 1; l < bstrm_pkg::TableLevels; l++) begin
            if ((BlkW+1)'(1 << l) <= w_cnt) w_lev = LevW'(l);
        end
    end

    // Read addresses and writes.
    always_comb begin
        v_we = 1'b0; p_we = 1'b0; s_we = 1'b0; t_we = 1'b0;
        v_wa = r_count[IdxW-1:0];
        v_wd = {i_in.elem_key ^ 32'h8000_0000, i_in.elem_payload};
        p_wa = r_rdidx; p_wd = r_first ? w_rd : w_min;
        s_wa = r_rdidx; s_wd = r_first ? w_rd : w_min;
        t_wa = taddr(r_lev, r_bi - 1'b1); t_wd = r_first ? w_rd : w_min;
        v_ra = r_i; p_ra = r_hi; s_ra = r_lo;
        t_ra = taddr(r_lev, r_bi);
        if (r_state == S_IDLE && i_valid && i_in.op == bstrm_pkg::OpLoad &&
            r_count < CntW'(bstrm_pkg::MaxElems)) v_we = 1'b1;
        if (r_state == S_PRE && r_rdv) p_we = 1'b1;
        if (r_state == S_SUF && r_rdv) s_we = 1'b1;
        if (r_state == S_TAB0) begin
            s_ra = IdxW'({r_bi, OffW'(0)});
            t_wa = taddr('0, r_bi - 1'b1);
            t_wd = s_rd;
            t_we = r_rdv;
        end
        if (r_state == S_TABL) begin
            t_ra = r_tabq ? taddr(r_lev - 1'b1, r_bi + BlkW'(1 << (r_lev - 1'b1)))
                          : taddr(r_lev - 1'b1, r_bi);
            t_wa = taddr(r_lev, r_bi);
            t_wd = w_min;
            t_we = r_rdv && !r_tabq;
        end
        if (r_state == S_QT1) t_ra = taddr(r_lev, r_lb);
        if (r_state == S_QT2)
            t_ra = taddr(r_lev, r_rb + 1'b1 - BlkW'(1 << r_lev));
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_out   = r_out;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_built <= 1'b0;
            r_ovf   <= 1'b0;
            r_rdv   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_rdv <= 1'b0;
                    r_first <= 1'b1;
                    if (i_valid) begin
                        r_lo <= i_in.range_low;
                        r_hi <= i_in.range_high;
                        case (i_in.op)
                            bstrm_pkg::OpLoad: begin
                                if (r_count >= CntW'(bstrm_pkg::MaxElems)) begin
                                    r_ovf <= 1'b1;
                                    r_out <= to_out(bstrm_pkg::NeutralPair, 1'b0, 1'b1);
                                    r_state <= S_OUT;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                    r_built <= 1'b0;
                                end
                            end
                            bstrm_pkg::OpBuild: begin
                                r_i <= '0;
                                r_state <= S_PRE;
                            end
                            bstrm_pkg::OpQuery: begin
                                r_acc <= bstrm_pkg::NeutralPair;
                                r_have <= 1'b0;
                                r_i <= i_in.range_low;
                                r_state <= S_OUT;
                                if (!r_built)
                                    r_out <= to_out(bstrm_pkg::NeutralPair, 1'b0, 1'b1);
                                else if (i_in.range_low > i_in.range_high)
                                    r_out <= to_out(bstrm_pkg::NeutralPair, 1'b1, r_ovf);
                                else if (CntW'(i_in.range_high) >= r_count)
                                    r_out <= to_out(bstrm_pkg::NeutralPair, 1'b0, 1'b1);
                                else if (i_in.range_low[IdxW-1:OffW] ==
                                         i_in.range_high[IdxW-1:OffW])
                                    r_state <= S_QSCAN;
                                else
                                    r_state <= S_QSUF;
                            end
                            default: ;
                        endcase
                    end
                end
                // Prefix pass: read element r_i, combine at the next cycle.
                S_PRE: begin
                    if (r_rdv) begin
                        r_acc <= p_wd;
                        r_first <= 1'b0;
                        r_rdv <= 1'b0;
                        if (r_rdidx[OffW-1:0] == OffW'(Bs - 1)) r_first <= 1'b1;
                        if (CntW'(r_rdidx) + 1'b1 >= r_count) begin
                            r_i <= IdxW'({w_nb, OffW'(0)} - 1);
                            r_first <= 1'b1;
                            r_state <= (w_nb == '0) ? S_TAB0 : S_SUF;
                            r_bi <= '0;
                        end else r_i <= r_rdidx + 1'b1;
                    end else if (r_count == '0) begin
                        r_state <= S_TAB0;
                        r_bi <= '0;
                    end else begin
                        r_rdidx <= r_i;
                        r_rdv <= 1'b1;
                    end
                end
                // Suffix pass from the end of the last whole block down.
                S_SUF: begin
                    if (r_rdv) begin
                        r_acc <= s_wd;
                        r_rdv <= 1'b0;
                        r_first <= (r_rdidx[OffW-1:0] == '0);
                        if (r_rdidx == '0) begin
                            r_state <= S_TAB0;
                            r_bi <= '0;
                        end else r_i <= r_rdidx - 1'b1;
                    end else begin
                        r_rdidx <= r_i;
                        r_rdv <= 1'b1;
                    end
                end
                // Level 0 takes the suffix minimum at each block start.
                S_TAB0: begin
                    if (r_rdv) begin
                        r_rdv <= 1'b0;
                    end else if (r_bi >= w_nb) begin
                        r_lev <= LevW'(1);
                        r_bi <= '0;
                        r_tabq <= 1'b0;
                        r_state <= (bstrm_pkg::TableLevels > 1) ? S_TABL : S_IDLE;
                        if (bstrm_pkg::TableLevels == 1) r_built <= 1'b1;
                    end else begin
                        r_bi <= r_bi + 1'b1;
                        r_rdv <= 1'b1;
                    end
                end
                // Higher levels: two reads then one write per entry.
                S_TABL: begin
                    if (r_rdv) begin
                        r_rdv <= 1'b0;
                        if (!r_tabq) begin
                            r_bi <= r_bi + 1'b1;
                        end else begin
                            r_acc <= t_rd;
                        end
                    end else if ((BlkW+1)'(r_bi) + (BlkW+1)'(1 << r_lev) >
                                 (BlkW+1)'(w_nb)) begin
                        r_bi <= '0;
                        r_tabq <= 1'b0;
                        if (r_lev == LevW'(bstrm_pkg::TableLevels - 1)) begin
                            r_built <= 1'b1;
                            r_state <= S_IDLE;
                        end else r_lev <= r_lev + 1'b1;
                    end else begin
                        r_rdv <= 1'b1;
                        r_tabq <= !r_tabq;
                    end
                end
                // Same-block scan, one element per cycle; the first element seeds
                // the minimum so that maximum-key pairs keep their payload.
                S_QSCAN: begin
                    if (r_rdv) begin
                        r_acc <= r_first ? w_rd : w_min;
                        r_first <= 1'b0;
                    end
                    if (r_i <= r_hi && !(r_rdv && r_rdidx == r_hi)) begin
                        r_rdidx <= r_i;
                        r_rdv <= 1'b1;
                        r_i <= r_i + 1'b1;
                    end else if (r_rdv && r_rdidx != r_hi) begin
                        r_rdv <= 1'b0;
                    end else begin
                        r_rdv <= 1'b0;
                        r_state <= S_QFIN;
                    end
                end
                // Partial edges, then compute the whole-block span.
                S_QSUF: begin
                    r_state <= S_QPRE;
                    r_lb <= BlkW'(r_lo >> OffW) + BlkW'(r_lo[OffW-1:0] != '0);
                    r_rb <= BlkW'(r_hi >> OffW) - BlkW'(r_hi[OffW-1:0] != OffW'(Bs-1));
                end
                S_QPRE: begin
                    if (r_lo[OffW-1:0] != '0) begin
                        r_acc <= s_rd;
                        r_have <= 1'b1;
                    end
                    r_prev <= p_rd;
                    r_lev <= w_lev;
                    r_state <= S_QT1;
                end
                // Fold in the prefix of the last block.
                S_QT1: begin
                    if (r_hi[OffW-1:0] != OffW'(Bs-1)) begin
                        r_acc <= r_have ? w_min : r_prev;
                        r_have <= 1'b1;
                    end
                    r_state <= S_QT2;
                end
                // Fold in the first table entry of the whole-block span.
                S_QT2: begin
                    if (r_lb <= r_rb) begin
                        r_acc <= r_have ? w_min : t_rd;
                        r_have <= 1'b1;
                    end
                    r_rdv <= 1'b1;
                    r_state <= S_QFIN;
                end
                S_QFIN: begin
                    if (r_rdv && r_lb <= r_rb)
                        r_acc <= w_min;
                    r_rdv <= 1'b0;
                    if (!r_rdv) begin
                        r_out <= to_out(r_acc, 1'b0, r_ovf);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("result dropped under stall");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(bstrm_pkg::MaxElems)) else $error("count overflow");
endmodule

FILE: design/bstrm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module bstrm_ram #(
    parameter int Depth = 1024,
    parameter int Width = 48,
    parameter int Aw    = $clog2(Depth)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [Aw-1:0]    i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [Aw-1:0]    i_raddr,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
